/* hw/rtl/bphm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphm_pkg
// Shared constants for the button press / hold mode controller: button bit
// positions, configuration register map and register reset values.
// ----------------------------------------------------------------------------
package bphm_pkg;

  localparam int unsigned NUM_BUTTONS = 4;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned REG_IDX_W   = 2;

  // button bit positions in a sample
  localparam int unsigned BTN1 = 0;
  localparam int unsigned BTN2 = 1;
  localparam int unsigned BTN3 = 2;
  localparam int unsigned BTN4 = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_PRESS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT      = 2'd2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd150;
  localparam logic [CFG_W-1:0] SHORT_PRESS_RST = 16'd1;
  localparam logic [CFG_W-1:0] REPEAT_RST      = 16'd40;

endpackage

/* hw/rtl/bphm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphm_in_if
// Button sample channel: valid/ready handshake with one 4-bit sample per item.
// ----------------------------------------------------------------------------
interface bphm_in_if;
  logic                             valid;
  logic                             ready;
  logic [bphm_pkg::NUM_BUTTONS-1:0] buttons;

  modport source (output valid, output buttons, input ready);
  modport sink   (input valid, input buttons, output ready);
  modport mon    (input valid, input buttons, input ready);
endinterface

/* hw/rtl/bphm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphm_out_if
// Result channel: valid/ready handshake carrying mode flags and pulses.
// ----------------------------------------------------------------------------
interface bphm_out_if;
  logic valid;
  logic ready;
  logic adjust_mode;
  logic twelve_hour;
  logic inc_hours;
  logic inc_minutes;
  logic inc_seconds;
  logic redraw;

  modport source (output valid, output adjust_mode, output twelve_hour, output inc_hours,
                  output inc_minutes, output inc_seconds, output redraw, input ready);
  modport sink   (input valid, input adjust_mode, input twelve_hour, input inc_hours,
                  input inc_minutes, input inc_seconds, input redraw, output ready);
  modport mon    (input valid, input adjust_mode, input twelve_hour, input inc_hours,
                  input inc_minutes, input inc_seconds, input redraw, input ready);
endinterface

/* hw/rtl/button_press_hold_mode_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_hold_mode_controller
// Result is registered: it is valid the cycle after its sample is accepted.
// Throughput: one item per cycle; the single result register reloads in the
// cycle it is taken, so ready stays high while the result side keeps up.
// Reset (rst, synchronous): normal mode, 24-hour display, counters and
// cooldown bits cleared, registers back to 150 / 1 / 40, no result pending.
// ----------------------------------------------------------------------------
module button_press_hold_mode_controller #(
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  bphm_in_if.sink                      sample,
  bphm_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bphm_pkg::ADDR_W-1:0]  paddr,
  input  logic [bphm_pkg::DATA_W-1:0]  pwdata,
  output logic [bphm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned CMP_W = (TICK_BITS > bphm_pkg::CFG_W) ? TICK_BITS : bphm_pkg::CFG_W;
  localparam int unsigned NB    = bphm_pkg::NUM_BUTTONS;

  logic [bphm_pkg::CFG_W-1:0] long_press_ticks;
  logic [bphm_pkg::CFG_W-1:0] short_press_ticks;
  logic [bphm_pkg::CFG_W-1:0] repeat_ticks;

  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] press_start;
  logic [NB-1:0]        last_buttons;
  logic [NB-1:0]        cooldown_bits;
  logic                 mode_is_set;
  logic                 twelve_hour_flag;

  logic [TICK_BITS-1:0] tick_count_next;
  logic [TICK_BITS-1:0] press_start_next;
  logic [NB-1:0]        cooldown_bits_next;
  logic                 mode_is_set_next;
  logic                 twelve_hour_flag_next;
  logic [2:0]           inc_next;

  logic [TICK_BITS-1:0] held;
  logic [CMP_W-1:0]     held_ext;
  logic                 gt_long;
  logic                 gt_short;
  logic                 gt_repeat;
  logic                 restarted;
  logic                 accept;
  logic                 cfg_write;
  logic [bphm_pkg::REG_IDX_W-1:0] reg_idx;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[bphm_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks  <= bphm_pkg::LONG_PRESS_RST;
      short_press_ticks <= bphm_pkg::SHORT_PRESS_RST;
      repeat_ticks      <= bphm_pkg::REPEAT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bphm_pkg::REG_LONG_PRESS:  long_press_ticks  <= pwdata[bphm_pkg::CFG_W-1:0];
        bphm_pkg::REG_SHORT_PRESS: short_press_ticks <= pwdata[bphm_pkg::CFG_W-1:0];
        bphm_pkg::REG_REPEAT:      repeat_ticks      <= pwdata[bphm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bphm_pkg::REG_LONG_PRESS:
        prdata = bphm_pkg::DATA_W'(long_press_ticks);
      bphm_pkg::REG_SHORT_PRESS:
        prdata = bphm_pkg::DATA_W'(short_press_ticks);
      bphm_pkg::REG_REPEAT:
        prdata = bphm_pkg::DATA_W'(repeat_ticks);
      default:
        prdata = '0;
    endcase
  end

  // ---------------- step logic ----------------
  // press_start only ever moves to the current tick, after which the held
  // time is zero and no compare can fire; one subtract serves every check.
  assign tick_count_next = tick_count + 1'b1;
  assign held            = tick_count_next - press_start;
  assign held_ext        = CMP_W'(held);
  assign gt_long         = held_ext > CMP_W'(long_press_ticks);
  assign gt_short        = held_ext > CMP_W'(short_press_ticks);
  assign gt_repeat       = held_ext > CMP_W'(repeat_ticks);

  always_comb begin
    logic [NB-1:0] now;
    now                   = sample.buttons;
    restarted             = 1'b0;
    cooldown_bits_next    = cooldown_bits;
    mode_is_set_next      = mode_is_set;
    twelve_hour_flag_next = twelve_hour_flag;
    inc_next              = '0;

    if (!mode_is_set) begin
      // button 4: long press enters set mode
      if (now[bphm_pkg::BTN4] && !cooldown_bits_next[bphm_pkg::BTN4]) begin
        if (!last_buttons[bphm_pkg::BTN4]) restarted = 1'b1;
        if (!restarted && gt_long) begin
          cooldown_bits_next[bphm_pkg::BTN4] = 1'b1;
          mode_is_set_next = 1'b1;
        end
      end
      if (!now[bphm_pkg::BTN4]) cooldown_bits_next[bphm_pkg::BTN4] = 1'b0;
      // button 1: short press toggles 12-hour display
      if (now[bphm_pkg::BTN1] && !cooldown_bits_next[bphm_pkg::BTN1]) begin
        if (!last_buttons[bphm_pkg::BTN1]) restarted = 1'b1;
        if (!restarted && gt_short) begin
          cooldown_bits_next[bphm_pkg::BTN1] = 1'b1;
          twelve_hour_flag_next = !twelve_hour_flag;
        end
      end
      if (!now[bphm_pkg::BTN1]) cooldown_bits_next[bphm_pkg::BTN1] = 1'b0;
    end else begin
      // button 4: short press leaves set mode
      if (now[bphm_pkg::BTN4] && !cooldown_bits_next[bphm_pkg::BTN4]) begin
        if (!last_buttons[bphm_pkg::BTN4]) restarted = 1'b1;
        if (!restarted && gt_short) begin
          cooldown_bits_next[bphm_pkg::BTN4] = 1'b1;
          mode_is_set_next = 1'b0;
        end
      end
      if (!now[bphm_pkg::BTN4]) cooldown_bits_next[bphm_pkg::BTN4] = 1'b0;
      // buttons 3, 2, 1 in that order: auto-repeat hours, minutes, seconds
      for (int i = 2; i >= 0; i--) begin
        if (now[2'(i)]) begin
          if (cooldown_bits_next[2'(i)]) begin
            if (!restarted && gt_repeat) begin
              restarted = 1'b1;
              cooldown_bits_next[2'(i)] = 1'b0;
            end
          end else begin
            if (!last_buttons[2'(i)]) restarted = 1'b1;
            if (!restarted && gt_short) begin
              cooldown_bits_next[2'(i)] = 1'b1;
              inc_next[2'(i)] = 1'b1;
            end
          end
        end
      end
    end

    press_start_next = restarted ? tick_count_next : press_start;
  end

  // ---------------- state and result register ----------------
  assign sample.ready = !result.valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      press_start      <= '0;
      last_buttons     <= '0;
      cooldown_bits    <= '0;
      mode_is_set      <= 1'b0;
      twelve_hour_flag <= 1'b0;
      result.valid     <= 1'b0;
    end else begin
      if (accept) begin
        tick_count       <= tick_count_next;
        press_start      <= press_start_next;
        last_buttons     <= sample.buttons;
        cooldown_bits    <= cooldown_bits_next;
        mode_is_set      <= mode_is_set_next;
        twelve_hour_flag <= twelve_hour_flag_next;
        result.valid     <= 1'b1;
      end else if (result.ready) begin
        result.valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.adjust_mode <= mode_is_set_next;
      result.twelve_hour <= twelve_hour_flag_next;
      result.inc_hours   <= inc_next[bphm_pkg::BTN3];
      result.inc_minutes <= inc_next[bphm_pkg::BTN2];
      result.inc_seconds <= inc_next[bphm_pkg::BTN1];
      result.redraw      <= |inc_next;
    end
  end

endmodule

/* hw/rtl/bphm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphm_checker
// Port-level checks for the mode controller, bound to the top level.
// ----------------------------------------------------------------------------
module bphm_checker (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic adjust_mode,
  input logic twelve_hour,
  input logic inc_hours,
  input logic inc_minutes,
  input logic inc_seconds,
  input logic redraw
);

  logic last_set;
  logic last_twelve;

  // mode flags of the last item taken from the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      last_set    <= 1'b0;
      last_twelve <= 1'b0;
    end else if (valid && ready) begin
      last_set    <= adjust_mode;
      last_twelve <= twelve_hour;
    end
  end

  a_redraw_any: assert property (@(posedge clk) disable iff (rst)
    valid |-> (redraw == (inc_hours || inc_minutes || inc_seconds)))
    else $error("redraw does not match increment pulses");

  a_inc_only_in_set: assert property (@(posedge clk) disable iff (rst)
    (valid && (inc_hours || inc_minutes || inc_seconds)) |-> last_set)
    else $error("increment pulse outside set mode");

  a_twelve_only_normal: assert property (@(posedge clk) disable iff (rst)
    (valid && (twelve_hour != last_twelve)) |-> !last_set)
    else $error("12-hour flag changed in set mode");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(adjust_mode) &&
      $stable(twelve_hour) && $stable(redraw)))
    else $error("stalled result changed");

endmodule

bind button_press_hold_mode_controller bphm_checker u_bphm_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .adjust_mode (result.adjust_mode),
  .twelve_hour (result.twelve_hour),
  .inc_hours   (result.inc_hours),
  .inc_minutes (result.inc_minutes),
  .inc_seconds (result.inc_seconds),
  .redraw      (result.redraw)
);

/* test/bphm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphm_scoreboard
// Watches the sample, result and register-write traffic of the button
// controller. It keeps its own copy of the press/hold state and of the
// registers, works out the expected flags for every accepted sample, and
// compares every accepted result with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module bphm_scoreboard #(
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  bphm_in_if.mon                        sample,
  bphm_out_if.mon                       result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [bphm_pkg::ADDR_W-1:0]   paddr,
  input  logic [bphm_pkg::DATA_W-1:0]   pwdata,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic adjust_mode;
    logic twelve_hour;
    logic inc_hours;
    logic inc_minutes;
    logic inc_seconds;
    logic redraw;
  } tick_flags_t;

  logic [bphm_pkg::CFG_W-1:0]       long_cfg;
  logic [bphm_pkg::CFG_W-1:0]       short_cfg;
  logic [bphm_pkg::CFG_W-1:0]       repeat_cfg;
  logic [TICK_BITS-1:0]             tick_now;
  logic [TICK_BITS-1:0]             press_tick;
  logic [bphm_pkg::NUM_BUTTONS-1:0] prev_btns;
  logic [bphm_pkg::NUM_BUTTONS-1:0] cooldown;
  logic                             in_set;
  logic                             twelve;
  tick_flags_t                      flags_q[$];
  int                               fail_count = 0;
  int                               waiting = 0;
  int                               results_seen = 0;

  assign errors  = fail_count;
  assign pending = waiting;

  // wraps at the counter width
  function automatic logic [TICK_BITS-1:0] hold_span();
    return tick_now - press_tick;
  endfunction

  // fires once per press; a release re-arms
  function automatic logic single_press(logic [bphm_pkg::NUM_BUTTONS-1:0] btns,
                                        int unsigned idx,
                                        logic [bphm_pkg::CFG_W-1:0] need);
    logic fired;
    fired = 1'b0;
    if (btns[idx] && !cooldown[idx]) begin
      if (!prev_btns[idx]) press_tick = tick_now;
      if (hold_span() > need) begin
        cooldown[idx] = 1'b1;
        fired = 1'b1;
      end
    end
    if (!btns[idx]) cooldown[idx] = 1'b0;
    return fired;
  endfunction

  // auto-repeat; cooldown only clears while still held
  function automatic logic repeat_press(logic [bphm_pkg::NUM_BUTTONS-1:0] btns,
                                        int unsigned idx,
                                        logic [bphm_pkg::CFG_W-1:0] need,
                                        logic [bphm_pkg::CFG_W-1:0] again);
    if (!btns[idx]) return 1'b0;
    if (cooldown[idx]) begin
      if (hold_span() > again) begin
        press_tick = tick_now;
        cooldown[idx] = 1'b0;
      end
      return 1'b0;
    end
    if (!prev_btns[idx]) press_tick = tick_now;
    if (hold_span() > need) begin
      cooldown[idx] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic tick_flags_t advance_tick(logic [bphm_pkg::NUM_BUTTONS-1:0] btns);
    tick_flags_t f;
    f = '0;
    tick_now = tick_now + 1'b1;
    if (!in_set) begin
      if (single_press(btns, bphm_pkg::BTN4, long_cfg)) in_set = 1'b1;
      if (single_press(btns, bphm_pkg::BTN1, short_cfg)) twelve = ~twelve;
    end else begin
      if (single_press(btns, bphm_pkg::BTN4, short_cfg)) in_set = 1'b0;
      f.inc_hours   = repeat_press(btns, bphm_pkg::BTN3, short_cfg, repeat_cfg);
      f.inc_minutes = repeat_press(btns, bphm_pkg::BTN2, short_cfg, repeat_cfg);
      f.inc_seconds = repeat_press(btns, bphm_pkg::BTN1, short_cfg, repeat_cfg);
    end
    prev_btns     = btns;
    f.adjust_mode = in_set;
    f.twelve_hour = twelve;
    f.redraw      = f.inc_hours | f.inc_minutes | f.inc_seconds;
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    tick_flags_t want;
    if (rst) begin
      long_cfg   = bphm_pkg::LONG_PRESS_RST;
      short_cfg  = bphm_pkg::SHORT_PRESS_RST;
      repeat_cfg = bphm_pkg::REPEAT_RST;
      tick_now   = '0;
      press_tick = '0;
      prev_btns  = '0;
      cooldown   = '0;
      in_set     = 1'b0;
      twelve     = 1'b0;
      flags_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[bphm_pkg::REG_IDX_W+1:2])
          bphm_pkg::REG_LONG_PRESS:  long_cfg   = pwdata[bphm_pkg::CFG_W-1:0];
          bphm_pkg::REG_SHORT_PRESS: short_cfg  = pwdata[bphm_pkg::CFG_W-1:0];
          bphm_pkg::REG_REPEAT:      repeat_cfg = pwdata[bphm_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) flags_q.push_back(advance_tick(sample.buttons));
      if (result.valid && result.ready) begin
        if (flags_q.size() == 0) begin
          report_mismatch("result with no sample outstanding");
        end else begin
          want = flags_q.pop_front();
          check_field("adjust_mode", result.adjust_mode, want.adjust_mode);
          check_field("twelve_hour", result.twelve_hour, want.twelve_hour);
          check_field("inc_hours",   result.inc_hours,   want.inc_hours);
          check_field("inc_minutes", result.inc_minutes, want.inc_minutes);
          check_field("inc_seconds", result.inc_seconds, want.inc_seconds);
          check_field("redraw",      result.redraw,      want.redraw);
        end
        results_seen++;
      end
    end
    waiting <= flags_q.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the button press / hold mode controller. Drives
// button samples with random gaps on both channels, rewrites the press
// registers between phases and stalls the result side for a long stretch.
// Checking is done by bphm_scoreboard.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LIMIT = 400000;
  localparam logic [bphm_pkg::NUM_BUTTONS-1:0] OPENING [24] = '{
    4'hF, 4'h0, 4'h6, 4'h6, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h0, 4'h4, 4'h4,
    4'h4, 4'h4, 4'h4, 4'h0, 4'h7, 4'h7, 4'h7, 4'hB, 4'h8, 4'h8, 4'h8, 4'h0
  };

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bphm_pkg::ADDR_W-1:0] paddr;
  logic [bphm_pkg::DATA_W-1:0] pwdata;
  logic [bphm_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  int unsigned send_idle = 22;
  int unsigned take_idle = 47;
  bit          long_hold = 1'b0;
  int unsigned items_sent = 0;
  int unsigned settings_done = 0;
  int unsigned cycles = 0;
  int unsigned cfg_long = 32'(bphm_pkg::LONG_PRESS_RST);
  int unsigned cfg_short = 32'(bphm_pkg::SHORT_PRESS_RST);
  int unsigned cfg_repeat = 32'(bphm_pkg::REPEAT_RST);
  int          fail_total;
  int          waiting_results;

  bphm_in_if  sample_if ();
  bphm_out_if result_if ();

  button_press_hold_mode_controller DUT (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bphm_scoreboard flag_check (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (fail_total),
    .pending (waiting_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random gaps, or one long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        result_if.ready <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold = 1'b0;
      end
      result_if.ready <= ($urandom_range(99) >= take_idle);
    end
  end

  task automatic send_sample(input logic [bphm_pkg::NUM_BUTTONS-1:0] btns);
    while ($urandom_range(99) < send_idle) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid   <= 1'b1;
    sample_if.buttons <= btns;
    do @(posedge clk); while (!sample_if.ready);
    items_sent++;
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (waiting_results != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bphm_pkg::REG_IDX_W-1:0] idx,
                           input logic [bphm_pkg::CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bphm_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= bphm_pkg::DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned lp, input int unsigned sp, input int unsigned rp);
    drain();
    write_reg(bphm_pkg::REG_LONG_PRESS, bphm_pkg::CFG_W'(lp));
    write_reg(bphm_pkg::REG_SHORT_PRESS, bphm_pkg::CFG_W'(sp));
    write_reg(bphm_pkg::REG_REPEAT, bphm_pkg::CFG_W'(rp));
    cfg_long   = lp;
    cfg_short  = sp;
    cfg_repeat = rp;
    settings_done++;
  endtask

  // mostly held presses with random content; some noise and cut-short holds
  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    int unsigned cap;
    logic [bphm_pkg::NUM_BUTTONS-1:0] pat;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      pat  = bphm_pkg::NUM_BUTTONS'($urandom_range(15));
      if (kind < 15) begin
        len = 1;
      end else if (kind < 35) begin
        pat[bphm_pkg::BTN4] = 1'b1;
        cap = (cfg_long > 30) ? 30 : cfg_long;
        len = cap + $urandom_range(0, 4);
        if (len == 0) len = 1;
      end else begin
        cap = cfg_short + cfg_repeat;
        if (cap > 30) cap = 30;
        len = $urandom_range(1, 2 * cap + 4);
      end
      repeat (len) send_sample(pat);
      if ($urandom_range(3) != 0) repeat ($urandom_range(1, 3)) send_sample('0);
    end
  endtask

  initial begin
    rst               <= 1'b1;
    sample_if.valid   <= 1'b0;
    sample_if.buttons <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // register reset values: short press of button 1
    send_sample(4'h0);
    repeat (3) send_sample(4'h1);
    send_sample(4'h0);

    set_config(3, 1, 2);
    foreach (OPENING[i]) send_sample(OPENING[i]);

    set_config(0, 0, 0);
    run_random(60);
    set_config(65535, 65535, 65535);
    run_random(30);
    set_config($urandom_range(0, 12), $urandom_range(0, 4), $urandom_range(0, 8));
    run_random(150);

    send_idle = 47;
    take_idle = 22;
    set_config($urandom_range(0, 12), $urandom_range(0, 4), $urandom_range(0, 8));
    run_random(220);

    send_idle = 0;
    take_idle = 0;
    set_config($urandom_range(0, 12), $urandom_range(0, 4), $urandom_range(0, 8));
    long_hold = 1'b1;
    run_random(220);

    // short fixed settings, no gaps
    set_config(2, 1, 3);
    run_random(40);

    drain();
    $display("%0d samples sent over %0d register settings,", items_sent, settings_done);
    $display("with gaps on both sides and a long result stall");
    if (fail_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
